### rtl/core/strict_priority_multi_queue_assert.svh
// assertion macros shared by the strict priority queue rtl
`ifndef STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH

// property checked at every clock edge outside reset
`define SPMQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define SPMQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/spmq_pkg.sv
// shared types and constants for the strict priority queue
`timescale 1ns / 1ps

package spmq_pkg;

  localparam int MaxLevelsDef  = 8;
  localparam int LevelDepthDef = 16;
  localparam int DataWidthDef  = 32;

  localparam logic [3:0] LevelsInUseRst = 4'd8;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_LEVEL = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input transaction
    logic exec;  // apply it and register the result
  } spmq_cmd_t;

endpackage

### rtl/core/spmq_ctrl.sv
// controller fsm: input capture, execute sequencing and result valid
`timescale 1ns / 1ps
`include "strict_priority_multi_queue_assert.svh"

module spmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spmq_pkg::spmq_cmd_t cmd_o
);
  import spmq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;

  // the result slot is free when empty or being taken this cycle
  assign fire = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SPMQ_ASSERT_NEXT(a_load_then_exec, cmd_o.load, state_q == S_EXEC, "capture did not enter execute")
  `SPMQ_ASSERT_NEXT(a_exec_gives_result, cmd_o.exec, out_valid_q, "execute produced no result")
  `SPMQ_ASSERT(a_load_exec_excl, !(cmd_o.load && cmd_o.exec), "capture and execute overlap")

endmodule

### rtl/core/spmq_dp.sv
// datapath: per-level pointers and counts, element memory, result registers
`timescale 1ns / 1ps
`include "strict_priority_multi_queue_assert.svh"

module spmq_dp #(
  parameter int MAX_LEVELS  = spmq_pkg::MaxLevelsDef,
  parameter int LEVEL_DEPTH = spmq_pkg::LevelDepthDef,
  parameter int DATA_WIDTH  = spmq_pkg::DataWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spmq_pkg::spmq_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              action_i,
  input  logic [2:0]        level_i,
  input  logic [31:0]       value_i,
  output logic [31:0]       head_value_o,
  output logic [2:0]        head_level_o,
  output logic              not_empty_o,
  output logic [7:0]        total_count_o,
  output logic [1:0]        status_o
);
  import spmq_pkg::*;

  localparam int LIW     = $clog2(MAX_LEVELS);
  localparam int PW      = $clog2(LEVEL_DEPTH);
  localparam int CW      = $clog2(LEVEL_DEPTH + 1);
  localparam int Entries = MAX_LEVELS * LEVEL_DEPTH;
  localparam int AW      = $clog2(Entries);
  localparam int TW      = $clog2(Entries + 1);

  localparam logic [CW-1:0] DepthCnt = CW'(LEVEL_DEPTH);
  localparam logic [PW-1:0] LastPtr  = PW'(LEVEL_DEPTH - 1);
  localparam logic [AW-1:0] DepthA   = AW'(LEVEL_DEPTH);
  localparam logic [5:0]    MaxLv6   = 6'(MAX_LEVELS);
  localparam logic [TW-1:0] CapTotal = TW'(Entries);

  // captured transaction
  action_e         action_q;
  logic [2:0]      level_q;
  logic [31:0]     value_q;

  logic [3:0]      liu_q;
  logic [PW-1:0]   head_ptr_q [MAX_LEVELS];
  logic [PW-1:0]   tail_ptr_q [MAX_LEVELS];
  logic [CW-1:0]   cnt_q      [MAX_LEVELS];
  logic [TW-1:0]   total_q;

  logic [DATA_WIDTH-1:0] mem_q [Entries];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [2:0]      head_level_q;
  logic            not_empty_q;
  status_e         status_q;

  logic [MAX_LEVELS-1:0] nonempty, new_ne;
  logic [7:0]      level_x;
  logic [LIW-1:0]  lidx, cur_lv, new_lv;
  logic            bad, full, push_ok, pop_ok, cur_any, new_any;
  status_e         status_d;
  logic [PW-1:0]   new_hp;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [63:0]     value_x, rd_x;
  logic [DATA_WIDTH-1:0] wr_data;

  function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
    return (p == LastPtr) ? '0 : p + PW'(1);
  endfunction

  // lowest set bit wins
  function automatic logic [LIW-1:0] first_set(logic [MAX_LEVELS-1:0] v);
    logic [LIW-1:0] idx;
    idx = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) idx = LIW'(i);
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
    end
  end

  assign level_x = {5'b0, level_q};
  assign lidx    = level_x[LIW-1:0];
  assign bad     = ({3'b0, level_q} >= {2'b0, liu_q}) || ({3'b0, level_q} >= MaxLv6);
  assign full    = (cnt_q[lidx] == DepthCnt);
  assign push_ok = (action_q == ACT_PUSH) && !bad && !full;
  assign cur_any = |nonempty;
  assign cur_lv  = first_set(nonempty);
  assign pop_ok  = (action_q == ACT_POP) && cur_any;

  always_comb begin
    priority if (action_q == ACT_PUSH && bad) begin
      status_d = ST_BAD_LEVEL;
    end else if (action_q == ACT_PUSH && full) begin
      status_d = ST_FULL;
    end else if (action_q == ACT_POP && !cur_any) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_OK;
    end
  end

  // occupancy after this transaction, to find the head it leaves
  always_comb begin
    new_ne = nonempty;
    if (push_ok) new_ne[lidx] = 1'b1;
    if (pop_ok && cnt_q[cur_lv] == CW'(1)) new_ne[cur_lv] = 1'b0;
  end

  assign new_any = |new_ne;
  assign new_lv  = first_set(new_ne);

  always_comb begin
    new_hp = head_ptr_q[new_lv];
    if (pop_ok && new_lv == cur_lv) new_hp = ptr_next(head_ptr_q[cur_lv]);
  end

  assign wr_addr = AW'(lidx) * DepthA + AW'(tail_ptr_q[lidx]);
  assign rd_addr = AW'(new_lv) * DepthA + AW'(new_hp);
  assign value_x = 64'(value_q);
  assign wr_data = value_x[DATA_WIDTH-1:0];

  // element memory, write-first on a push that becomes the new head
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (push_ok) mem_q[wr_addr] <= wr_data;
      rd_q <= (push_ok && wr_addr == rd_addr) ? wr_data : mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_e'(action_i);
      level_q  <= level_i;
      value_q  <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      liu_q <= LevelsInUseRst;
    end else if (cfg_we_i) begin
      liu_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_ptr_q[i] <= '0;
        tail_ptr_q[i] <= '0;
        cnt_q[i]      <= '0;
      end
      total_q      <= '0;
      head_level_q <= '0;
      not_empty_q  <= 1'b0;
      status_q     <= ST_OK;
    end else if (cmd_i.exec) begin
      if (push_ok) begin
        tail_ptr_q[lidx] <= ptr_next(tail_ptr_q[lidx]);
        cnt_q[lidx]      <= cnt_q[lidx] + CW'(1);
        total_q          <= total_q + TW'(1);
      end
      if (pop_ok) begin
        head_ptr_q[cur_lv] <= ptr_next(head_ptr_q[cur_lv]);
        cnt_q[cur_lv]      <= cnt_q[cur_lv] - CW'(1);
        total_q            <= total_q - TW'(1);
      end
      head_level_q <= new_any ? 3'(new_lv) : 3'b0;
      not_empty_q  <= new_any;
      status_q     <= status_d;
    end
  end

  assign rd_x          = 64'(rd_q);
  assign head_value_o  = not_empty_q ? rd_x[31:0] : 32'b0;
  assign head_level_o  = head_level_q;
  assign not_empty_o   = not_empty_q;
  assign total_count_o = 8'(total_q);
  assign status_o      = status_q;

  `SPMQ_ASSERT(a_flag_matches_total, not_empty_q == (total_q != '0), "not_empty disagrees with total")
  `SPMQ_ASSERT(a_total_bound, total_q <= CapTotal, "total count above capacity")
  `SPMQ_ASSERT_NEXT(a_push_counts, cmd_i.exec && push_ok, total_q == $past(total_q) + TW'(1), "push did not grow total")

endmodule

### rtl/core/strict_priority_multi_queue.sv
// strict priority multi-level fifo queue, top level
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid_i/in_ready_o | action_i, level_i, value_i
//   result  | out       | out_valid_o/out_ready_i | head_value_o, head_level_o,
//           |           |                       | not_empty_o, total_count_o, status_o
//   config  | in        | cfg_we_i              | cfg_wdata_i (levels in use)
//
// each transaction is first captured, then executed: the execute step updates the
// level pointers and counts and reads the new head from the element memory port.
// the result register frees the input side: a new transaction is taken while
// a result waits, and only its execute cycle waits for the result to be taken.
// reset clears pointers and counts and sets levels in use to 8; the memory is not cleared.
`timescale 1ns / 1ps

module strict_priority_multi_queue #(
  parameter int MAX_LEVELS  = spmq_pkg::MaxLevelsDef,
  parameter int LEVEL_DEPTH = spmq_pkg::LevelDepthDef,
  parameter int DATA_WIDTH  = spmq_pkg::DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [2:0]  level_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] head_value_o,
  output logic [2:0]  head_level_o,
  output logic        not_empty_o,
  output logic [7:0]  total_count_o,
  output logic [1:0]  status_o
);
  import spmq_pkg::*;

  spmq_cmd_t cmd;

  spmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  spmq_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .level_i      (level_i),
    .value_i      (value_i),
    .head_value_o (head_value_o),
    .head_level_o (head_level_o),
    .not_empty_o  (not_empty_o),
    .total_count_o(total_count_o),
    .status_o     (status_o)
  );

endmodule
